FILE: design/itsc_pkg.sv
// Package for the interval timing statistics core: shared types, command codes
// and arithmetic constants.
// Used by itsc_ctrl, itsc_datapath and interval_timing_statistics_core.
package itsc_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  // Register map (word index of the APB-style port).
  localparam logic [1:0] REG_REPORT_INTERVAL = 2'd0;
  localparam logic [7:0] REPORT_INTERVAL_RST = 8'd60;

  // Percent scaling in Q.8: 100 * 256.
  localparam int unsigned PCT_SCALE = 25600;

  // Widths of the shared arithmetic units.
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned DIV_W  = 80;
  localparam int unsigned ROOT_W = 40;
  localparam int unsigned CNT_W  = 7;

  // Iterations of each bit-serial unit.
  localparam int unsigned MUL_STEPS  = 64;
  localparam int unsigned DIV_STEPS  = 80;
  localparam int unsigned SQRT_STEPS = 40;

  typedef enum logic [1:0] {
    DIV_SEL_MEAN,
    DIV_SEL_VAR,
    DIV_SEL_PCT
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     do_start;
    logic     do_stop;
    logic     do_report;
    logic     mul_load_sq;
    logic     mul_load_m2;
    logic     mul_step;
    logic     div_load;
    div_sel_e div_sel;
    logic     div_step;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     acc_update;
    logic     fin;
    logic     out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic depth_one;
    logic countdown_zero;
    logic count_zero;
  } dp_stat_t;

endpackage

FILE: design/itsc_ctrl.sv
// Controller state machine of the interval timing statistics core.
// Sequences the datapath's multiplier, divider and square root; uses itsc_pkg.
module itsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         cmd_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  itsc_pkg::dp_stat_t stat_i,
  output itsc_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_MEAN = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_VAR  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_PCT  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]                 state_q, state_d;
  logic [itsc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       first_q, first_d;
  logic                       ovalid_q, ovalid_d;
  logic                       accept;
  logic                       last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign last        = !first_q && (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    cmd_o   = '0;
    cmd_o.div_sel = itsc_pkg::DIV_SEL_MEAN;
    if (!first_q && cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            itsc_pkg::CMD_START: cmd_o.do_start = 1'b1;
            itsc_pkg::CMD_STOP: begin
              cmd_o.do_stop = 1'b1;
              if (stat_i.depth_one) begin
                state_d = S_SQ;
                first_d = 1'b1;
                cnt_d   = itsc_pkg::CNT_W'(itsc_pkg::MUL_STEPS - 1);
              end
            end
            itsc_pkg::CMD_REPORT: begin
              cmd_o.do_report = 1'b1;
              first_d = 1'b1;
              cnt_d   = itsc_pkg::CNT_W'(itsc_pkg::DIV_STEPS - 1);
              if (!stat_i.countdown_zero) begin
                state_d = S_OUT;
              end else if (stat_i.count_zero) begin
                state_d = S_PCT;
              end else begin
                state_d = S_MEAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SQ: begin
        cmd_o.mul_load_sq = first_q;
        cmd_o.mul_step    = !first_q;
        first_d = 1'b0;
        if (last) state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_update = 1'b1;
        state_d = S_IDLE;
      end
      S_MEAN: begin
        cmd_o.div_load = first_q;
        cmd_o.div_step = !first_q;
        cmd_o.div_sel  = itsc_pkg::DIV_SEL_MEAN;
        first_d = 1'b0;
        if (last) begin
          state_d = S_M2;
          first_d = 1'b1;
          cnt_d   = itsc_pkg::CNT_W'(itsc_pkg::MUL_STEPS - 1);
        end
      end
      S_M2: begin
        cmd_o.mul_load_m2 = first_q;
        cmd_o.mul_step    = !first_q;
        first_d = 1'b0;
        if (last) begin
          state_d = S_VAR;
          first_d = 1'b1;
          cnt_d   = itsc_pkg::CNT_W'(itsc_pkg::DIV_STEPS - 1);
        end
      end
      S_VAR: begin
        cmd_o.div_load = first_q;
        cmd_o.div_step = !first_q;
        cmd_o.div_sel  = itsc_pkg::DIV_SEL_VAR;
        first_d = 1'b0;
        if (last) begin
          state_d = S_SQRT;
          first_d = 1'b1;
          cnt_d   = itsc_pkg::CNT_W'(itsc_pkg::SQRT_STEPS - 1);
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_load = first_q;
        cmd_o.sqrt_step = !first_q;
        first_d = 1'b0;
        if (last) begin
          state_d = S_PCT;
          first_d = 1'b1;
          cnt_d   = itsc_pkg::CNT_W'(itsc_pkg::DIV_STEPS - 1);
        end
      end
      S_PCT: begin
        cmd_o.div_load = first_q;
        cmd_o.div_step = !first_q;
        cmd_o.div_sel  = itsc_pkg::DIV_SEL_PCT;
        first_d = 1'b0;
        if (last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      first_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      first_q  <= first_d;
      ovalid_q <= ovalid_d;
    end
  end

`ifndef SYNTHESIS
  // A repeated report goes straight to the output stage.
  a_held_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_report && !stat_i.countdown_zero |=> state_q == S_OUT)
    else $error("held report did not go to the output stage");

  // The outermost stop always starts the squaring pass.
  a_stop_squares: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_stop && stat_i.depth_one |=> state_q == S_SQ && first_q)
    else $error("outermost stop did not start squaring");

  // Only one arithmetic unit iterates at a time.
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.mul_step, cmd_o.div_step, cmd_o.sqrt_step}))
    else $error("two arithmetic units stepped together");

  // A new result is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !ovalid_q || out_ready_i)
    else $error("result overwritten before it was taken");
`endif

endmodule

FILE: design/itsc_datapath.sv
// Datapath of the interval timing statistics core: accumulators, report
// registers and bit-serial multiplier, divider and square root. Uses itsc_pkg.
module itsc_datapath #(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itsc_pkg::dp_cmd_t    cmd_i,
  input  logic [TIME_BITS-1:0] now_us_i,
  input  logic [7:0]           report_interval_i,
  output itsc_pkg::dp_stat_t   stat_o,
  output logic [31:0]          call_count_o,
  output logic [63:0]          total_us_o,
  output logic [47:0]          min_us_o,
  output logic [47:0]          max_us_o,
  output logic [63:0]          mean_q8_o,
  output logic [39:0]          stdev_q8_o,
  output logic [31:0]          frame_percent_q8_o,
  output logic                 fresh_o
);

  localparam int unsigned AW = itsc_pkg::ACC_W;
  localparam int unsigned DW = itsc_pkg::DIV_W;
  localparam int unsigned RW = itsc_pkg::ROOT_W;

  // Nesting and accumulators.
  logic [DEPTH_BITS-1:0] depth_q;
  logic [TIME_BITS-1:0]  istart_q, d_q, min_q, max_q, fstart_q, flen_q;
  logic [AW-1:0]         sum_q, sq_q;
  logic [31:0]           count_q;
  logic [7:0]            cd_q;
  logic                  fresh_q;

  // Held report.
  logic [31:0] h_count_q;
  logic [63:0] h_sum_q, h_mean_q;
  logic [47:0] h_min_q, h_max_q;
  logic [39:0] h_sd_q;
  logic [31:0] h_pct_q;

  // Arithmetic units.
  logic [AW-1:0]   mcand_q, mean_q;
  logic [2*AW-1:0] prod_q;
  logic [DW-1:0]   quo_q;
  logic [AW:0]     rem_q;
  logic [AW-1:0]   dvs_q;
  logic [DW-1:0]   rad_q;
  logic [RW+1:0]   srem_q;
  logic [RW-1:0]   root_q;

  logic [AW:0]     mul_sum;
  logic [AW:0]     div_sh;
  logic            div_ge;
  logic [RW+3:0]   sq_r2, sq_trial;
  logic            sq_ge;
  logic [AW-1:0]   mean_sat;
  logic [2*AW-1:0] a_ext;
  logic [DW-1:0]   var_v;
  logic [DW-1:0]   dividend;
  logic [AW-1:0]   divisor;
  logic [TIME_BITS-1:0] interval;

  assign stat_o.depth_one      = (depth_q == DEPTH_BITS'(1));
  assign stat_o.countdown_zero = (cd_q == '0);
  assign stat_o.count_zero     = (count_q == '0);

  assign interval = now_us_i - istart_q;
  assign mul_sum  = {1'b0, prod_q[2*AW-1:AW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign div_sh   = {rem_q[AW-1:0], quo_q[DW-1]};
  assign div_ge   = (div_sh >= {1'b0, dvs_q});
  assign sq_r2    = {srem_q, rad_q[DW-1:DW-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_r2 >= sq_trial);
  assign mean_sat = (quo_q[DW-1:AW] != '0) ? '1 : quo_q[AW-1:0];
  assign a_ext    = (2*AW)'(quo_q);
  assign var_v    = (a_ext > prod_q) ? DW'(a_ext - prod_q) : '0;

  always_comb begin
    case (cmd_i.div_sel)
      itsc_pkg::DIV_SEL_MEAN: begin
        dividend = DW'({sum_q, 8'd0});
        divisor  = AW'(count_q);
      end
      itsc_pkg::DIV_SEL_VAR: begin
        dividend = DW'({sq_q, 16'd0});
        divisor  = AW'(count_q);
      end
      default: begin
        dividend = DW'(sum_q) * DW'(itsc_pkg::PCT_SCALE);
        divisor  = AW'(flen_q);
      end
    endcase
  end

  // Arithmetic units: one bit per step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load_sq) begin
      mcand_q <= AW'(d_q);
      prod_q  <= (2*AW)'(d_q);
    end else if (cmd_i.mul_load_m2) begin
      mcand_q <= mean_sat;
      prod_q  <= (2*AW)'(mean_sat);
      mean_q  <= mean_sat;
    end else if (cmd_i.mul_step) begin
      prod_q <= {mul_sum, prod_q[AW-1:1]};
    end
    if (cmd_i.div_load) begin
      quo_q <= dividend;
      rem_q <= '0;
      dvs_q <= divisor;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DW-2:0], div_ge};
      rem_q <= div_ge ? div_sh - {1'b0, dvs_q} : div_sh;
    end
    if (cmd_i.sqrt_load) begin
      rad_q  <= var_v;
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[DW-3:0], 2'b00};
      srem_q <= sq_ge ? (RW+2)'(sq_r2 - sq_trial) : (RW+2)'(sq_r2);
      root_q <= {root_q[RW-2:0], sq_ge};
    end
    if (cmd_i.out_load) begin
      call_count_o       <= h_count_q;
      total_us_o         <= h_sum_q;
      min_us_o           <= h_min_q;
      max_us_o           <= h_max_q;
      mean_q8_o          <= h_mean_q;
      stdev_q8_o         <= h_sd_q;
      frame_percent_q8_o <= h_pct_q;
      fresh_o            <= fresh_q;
    end
  end

  // Model state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= '0;
      istart_q  <= '0;
      d_q       <= '0;
      sum_q     <= '0;
      min_q     <= '1;
      max_q     <= '0;
      sq_q      <= '0;
      count_q   <= '0;
      fstart_q  <= '0;
      flen_q    <= '0;
      cd_q      <= '0;
      fresh_q   <= 1'b0;
      h_count_q <= '0;
      h_sum_q   <= '0;
      h_min_q   <= '0;
      h_max_q   <= '0;
      h_mean_q  <= '0;
      h_sd_q    <= '0;
      h_pct_q   <= '0;
    end else begin
      if (cmd_i.do_start) begin
        if (depth_q == '0) istart_q <= now_us_i;
        if (depth_q != '1) depth_q <= depth_q + 1'b1;
      end
      if (cmd_i.do_stop && depth_q != '0) begin
        depth_q <= depth_q - 1'b1;
        d_q     <= interval;
      end
      if (cmd_i.acc_update) begin
        sum_q <= sum_q + AW'(d_q);
        sq_q  <= sq_q + prod_q[AW-1:0];
        if (d_q < min_q) min_q <= d_q;
        if (d_q > max_q) max_q <= d_q;
        if (count_q != '1) count_q <= count_q + 1'b1;
      end
      if (cmd_i.do_report) begin
        if (cd_q != '0) begin
          cd_q    <= cd_q - 1'b1;
          fresh_q <= 1'b0;
        end else begin
          cd_q     <= (report_interval_i == '0) ? '0 : report_interval_i - 1'b1;
          flen_q   <= now_us_i - fstart_q;
          fstart_q <= now_us_i;
          fresh_q  <= 1'b1;
        end
      end
      if (cmd_i.fin) begin
        h_count_q <= count_q;
        h_sum_q   <= sum_q;
        h_min_q   <= (count_q == '0) ? '0 : 48'(AW'(min_q));
        h_max_q   <= 48'(AW'(max_q));
        h_mean_q  <= (count_q == '0) ? '0 : mean_q;
        h_sd_q    <= (count_q == '0) ? '0 : root_q;
        if (flen_q == '0) begin
          h_pct_q <= '0;
        end else begin
          h_pct_q <= (quo_q[DW-1:32] != '0) ? '1 : quo_q[31:0];
        end
        sum_q   <= '0;
        min_q   <= '1;
        max_q   <= '0;
        sq_q    <= '0;
        count_q <= '0;
      end
    end
  end

endmodule

FILE: design/interval_timing_statistics_core.sv
// Top level of the interval timing statistics core: APB-style register,
// controller and datapath. Uses itsc_pkg, itsc_ctrl and itsc_datapath.
//
// The core times nested start/stop intervals against a free-running
// microsecond timestamp and reports count, sum, minimum, maximum, mean,
// standard deviation and share of the frame, the last three in Q.8.
// Only the outermost stop closes an interval; a stop at depth zero is
// ignored. A report item recomputes the statistics once every
// report_interval report items and re-emits the held result otherwise;
// every report item yields exactly one result item, flagged by fresh.
// Start, stop of an inner level and unused command codes are handled in the
// idle state. A stop that closes the outermost interval also runs the
// bit-serial 64-bit multiplier that squares the interval. A repeated report
// goes straight to the output stage. A fresh report runs three passes of the
// 80-step restoring divider, one pass of the 64-step multiplier and the
// 40-step square root; with no interval recorded, only the percent division.
// The core takes one item at a time; a finished result waits in an output
// register, so start and stop items keep flowing while it is not yet taken.
// The register report_interval sits at byte address 0 and resets to 60;
// a value of zero behaves as one.
module interval_timing_statistics_core #(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Input items.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [TIME_BITS-1:0] now_us_i,
  // Result items.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          call_count_o,
  output logic [63:0]          total_us_o,
  output logic [47:0]          min_us_o,
  output logic [47:0]          max_us_o,
  output logic [63:0]          mean_q8_o,
  output logic [39:0]          stdev_q8_o,
  output logic [31:0]          frame_percent_q8_o,
  output logic                 fresh_o
);

  logic [7:0]         report_interval_q;
  itsc_pkg::dp_cmd_t  dp_cmd;
  itsc_pkg::dp_stat_t dp_stat;

  // There is a single register; a write to any other address is dropped.
  assign pready = 1'b1;
  assign prdata = {24'd0, report_interval_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_interval_q <= itsc_pkg::REPORT_INTERVAL_RST;
    end else if (psel && penable && pwrite && paddr == itsc_pkg::REG_REPORT_INTERVAL) begin
      report_interval_q <= pwdata[7:0];
    end
  end

  itsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  itsc_datapath #(
    .TIME_BITS  (TIME_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .now_us_i           (now_us_i),
    .report_interval_i  (report_interval_q),
    .stat_o             (dp_stat),
    .call_count_o       (call_count_o),
    .total_us_o         (total_us_o),
    .min_us_o           (min_us_o),
    .max_us_o           (max_us_o),
    .mean_q8_o          (mean_q8_o),
    .stdev_q8_o         (stdev_q8_o),
    .frame_percent_q8_o (frame_percent_q8_o),
    .fresh_o            (fresh_o)
  );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for interval_timing_statistics_core: directed table, then
// random start/stop/report traffic, checked against an in-bench statistics predictor.
// Depends on itsc_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected report, field by field as the core presents it.
  typedef struct {
    logic [31:0] call_count;
    logic [63:0] total_us;
    logic [47:0] min_us;
    logic [47:0] max_us;
    logic [63:0] mean_q8;
    logic [39:0] stdev_q8;
    logic [31:0] frame_percent_q8;
    logic        fresh;
  } report_t;

  // A row of the directed table. Where chk is set the predicted report must also
  // equal the typed-in values for count, total, minimum and fresh.
  typedef struct {
    logic [1:0]  cmd;
    logic [47:0] now;
    logic        chk;
    logic [31:0] cnt;
    logic [63:0] tot;
    logic [47:0] mn;
    logic        fr;
  } row_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int N_ROWS = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = itsc_pkg::CMD_START;
  logic [47:0] now_us_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] call_count_o;
  logic [63:0] total_us_o;
  logic [47:0] min_us_o, max_us_o;
  logic [63:0] mean_q8_o;
  logic [39:0] stdev_q8_o;
  logic [31:0] frame_percent_q8_o;
  logic        fresh_o;

  always #1 clk_i = ~clk_i;

  interval_timing_statistics_core i_dut (.*);

  // Predictor state: a private copy of everything the core keeps.
  logic [7:0]  p_interval;
  logic [7:0]  p_depth;
  logic [47:0] p_istart, p_min, p_max, p_fstart, p_flen;
  logic [63:0] p_sum, p_sq;
  logic [31:0] p_cnt;
  logic [7:0]  p_countdown;
  report_t     p_held;

  report_t     pending_reports[$];
  int          mismatches = 0;
  int          send_idle = 37, recv_idle = 63;
  logic [47:0] clock_now = '0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic reset_model();
    p_interval = itsc_pkg::REPORT_INTERVAL_RST;
    p_depth = '0; p_istart = '0; p_fstart = '0; p_flen = '0; p_countdown = '0;
    p_sum = '0; p_sq = '0; p_cnt = '0; p_min = TMAX; p_max = '0;
    p_held = '{default: '0};
  endtask

  // Computes the fresh statistics from the accumulators, in plain wide integers.
  function automatic report_t fresh_stats();
    report_t r;
    logic [127:0] a, m2, v, n, sd;
    logic [63:0] q, mean;
    r = '{default: '0};
    mean = '0;
    sd = '0;
    if (p_cnt != 0) begin
      q = p_sum / p_cnt;
      mean = (q >= 64'h0100_0000_0000_0000) ? '1 :
             64'(({64'd0, p_sum} << 8) / p_cnt);
      a = ({64'd0, p_sq} << 16) / p_cnt;
      m2 = {64'd0, mean} * {64'd0, mean};
      v = (a <= m2) ? '0 : a - m2;
      for (int b = 63; b >= 0; b--) begin
        if (((sd | (128'd1 << b)) * (sd | (128'd1 << b))) <= v) sd |= 128'd1 << b;
      end
      if (sd > 128'hFF_FFFF_FFFF) sd = 128'hFF_FFFF_FFFF;
    end
    if (p_flen != 0) begin
      n = {64'd0, p_sum} * 128'd25600;
      n = n / p_flen;
      r.frame_percent_q8 = (n > 128'hFFFF_FFFF) ? '1 : n[31:0];
    end
    r.call_count = p_cnt;
    r.total_us = p_sum;
    r.min_us = (p_cnt != 0) ? p_min : '0;
    r.max_us = p_max;
    r.mean_q8 = mean;
    r.stdev_q8 = sd[39:0];
    return r;
  endfunction

  // Advances the predictor by one item; returns 1 with the report when one is due.
  function automatic bit predict_item(input logic [1:0] cmd, input logic [47:0] now,
                                      output report_t r);
    logic [47:0] d;
    r = p_held;
    case (cmd)
      itsc_pkg::CMD_START: begin
        if (p_depth == 0) p_istart = now;
        if (p_depth != 8'hFF) p_depth++;
        return 0;
      end
      itsc_pkg::CMD_STOP: begin
        if (p_depth == 0) return 0;
        p_depth--;
        if (p_depth == 0) begin
          d = now - p_istart;
          p_sum += d;
          if (d < p_min) p_min = d;
          if (d > p_max) p_max = d;
          p_sq += {16'd0, d} * {16'd0, d};
          if (p_cnt != '1) p_cnt++;
        end
        return 0;
      end
      itsc_pkg::CMD_REPORT: begin
        if (p_countdown > 0) begin
          p_countdown--;
          r.fresh = 1'b0;
          return 1;
        end
        p_countdown = (p_interval == 0) ? 8'd0 : p_interval - 8'd1;
        p_flen = now - p_fstart;
        p_fstart = now;
        p_held = fresh_stats();
        p_held.fresh = 1'b0;
        p_sum = '0; p_sq = '0; p_cnt = '0; p_min = TMAX; p_max = '0;
        r = p_held;
        r.fresh = 1'b1;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Sends one item, holding valid steady until the core takes it. Valid stays
  // high after the transfer so that a following item can go back to back.
  task automatic send_item(input logic [1:0] cmd, input logic [47:0] now, output report_t r,
                           output bit has_report);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    now_us_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    has_report = predict_item(cmd, now, r);
    if (has_report) pending_reports.insert(pending_reports.size(), r);
  endtask

  task automatic write_interval(input logic [7:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= itsc_pkg::REG_REPORT_INTERVAL; pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    p_interval = value;
  endtask

  // Stops sending, waits until every report has arrived, then for the longest
  // internal pass.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Receiver side: random stall, compare the oldest expectation on each transfer.
  always @(posedge clk_i) begin
    report_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("unexpected report", 64'(call_count_o), 64'd0);
        end else begin
          w = pending_reports.pop_front();
          if (call_count_o !== w.call_count)
            report_mismatch("call_count", 64'(call_count_o), 64'(w.call_count));
          if (total_us_o !== w.total_us)
            report_mismatch("total_us", total_us_o, w.total_us);
          if (min_us_o !== w.min_us)
            report_mismatch("min_us", 64'(min_us_o), 64'(w.min_us));
          if (max_us_o !== w.max_us)
            report_mismatch("max_us", 64'(max_us_o), 64'(w.max_us));
          if (mean_q8_o !== w.mean_q8)
            report_mismatch("mean_q8", mean_q8_o, w.mean_q8);
          if (stdev_q8_o !== w.stdev_q8)
            report_mismatch("stdev_q8", 64'(stdev_q8_o), 64'(w.stdev_q8));
          if (frame_percent_q8_o !== w.frame_percent_q8)
            report_mismatch("frame_percent_q8", 64'(frame_percent_q8_o),
                            64'(w.frame_percent_q8));
          if (fresh_o !== w.fresh)
            report_mismatch("fresh", 64'(fresh_o), 64'(w.fresh));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Random timestamp step: mostly small, sometimes huge so the clock wraps.
  function automatic logic [47:0] next_time();
    case ($urandom_range(9))
      0: return 48'({$urandom, $urandom});
      1: return clock_now + (($urandom_range(1) == 1) ? 48'({$urandom, $urandom}) :
                             48'hFFFF);
      default: return clock_now + 48'($urandom_range(2000));
    endcase
  endfunction

  // Walks one random burst: mostly well-formed nested intervals, then at times a report.
  task automatic random_burst();
    report_t r;
    bit h;
    int lvl;
    lvl = $urandom_range(3, 1);
    if ($urandom_range(9) == 0) begin
      // Noise: any command, including unused ones and stray stops.
      clock_now = next_time();
      send_item(2'($urandom_range(3)), clock_now, r, h);
      return;
    end
    for (int k = 0; k < lvl; k++) begin
      clock_now = next_time();
      send_item(itsc_pkg::CMD_START, clock_now, r, h);
    end
    for (int k = 0; k < lvl; k++) begin
      clock_now = next_time();
      send_item(itsc_pkg::CMD_STOP, clock_now, r, h);
    end
    if ($urandom_range(2) == 0) begin
      clock_now = next_time();
      send_item(itsc_pkg::CMD_REPORT, clock_now, r, h);
    end
  endtask

  // Directed table: reset behaviour, extremes, nesting, wrap, stray and unused codes.
  row_t rows[N_ROWS] = '{
    '{itsc_pkg::CMD_REPORT, 48'd100, 1, 32'd0, 64'd0, 48'd0, 1}, // first report is fresh
    '{itsc_pkg::CMD_STOP,   48'd5,   0, 0, 0, 0, 0},  // stop at depth zero is ignored
    '{CMD_UNUSED,           48'd7,   0, 0, 0, 0, 0},  // unused code is ignored
    '{itsc_pkg::CMD_START,  TMAX - 48'd9, 0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_START,  48'd1,   0, 0, 0, 0, 0},  // nested start keeps the outer time
    '{itsc_pkg::CMD_STOP,   48'd2,   0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_STOP,   48'd10,  0, 0, 0, 0, 0},  // wraps round: interval of 20
    // Held copy of the first report under interval 3.
    '{itsc_pkg::CMD_REPORT, 48'd300, 1, 32'd0, 64'd0, 48'd0, 0},
    '{itsc_pkg::CMD_START,  48'd0,   0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_STOP,   TMAX,    0, 0, 0, 0, 0},  // largest interval
    '{itsc_pkg::CMD_START,  48'd50,  0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_STOP,   48'd50,  0, 0, 0, 0, 0},  // zero length interval
    '{itsc_pkg::CMD_REPORT, 48'd400, 0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_REPORT, 48'd0,   0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_START,  TMAX,    0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_STOP,   48'h5555_5555_5555, 0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_START,  48'hAAAA_AAAA_AAAA, 0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_STOP,   48'hAAAA_AAAA_AAAB, 0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_REPORT, 48'd500, 0, 0, 0, 0, 0},
    '{itsc_pkg::CMD_REPORT, 48'd600, 0, 0, 0, 0, 0}
  };

  initial begin
    report_t r;
    bit h;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with report interval 3, so that held copies show up too.
    write_interval(8'd3);
    for (int i = 0; i < N_ROWS; i++) begin
      send_item(rows[i].cmd, rows[i].now, r, h);
      if (rows[i].chk && (r.call_count !== rows[i].cnt || r.total_us !== rows[i].tot ||
                          r.min_us !== rows[i].mn || r.fresh !== rows[i].fr))
        report_mismatch("directed row", 64'(i), 64'(rows[i].cnt));
    end
    drain();

    // Saturate the nesting depth, then unwind: only the outermost stop measures.
    for (int k = 0; k < 260; k++) send_item(itsc_pkg::CMD_START, 48'(k), r, h);
    for (int k = 0; k < 256; k++) send_item(itsc_pkg::CMD_STOP, 48'(1000 + k), r, h);
    send_item(itsc_pkg::CMD_REPORT, 48'd9999, r, h);
    drain();

    // Random part over several settings, extremes included, and three levels of idling.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_interval(8'd1);
        1: write_interval(8'd0);
        2: write_interval(8'd255);
        3: write_interval(8'($urandom_range(8, 2)));
        4: write_interval(8'd1);
        default: write_interval(8'd2);
      endcase
      send_idle = (ph < 2) ? 37 : (ph < 4) ? 63 : 0;
      recv_idle = (ph < 2) ? 63 : (ph < 4) ? 37 : 0;
      for (int k = 0; k < 34; k++) random_burst();
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
